[rtl/isstore_pkg.sv]
// Shared types and constants for the indexed sequence store.
package isstore_pkg;

   localparam int DATA_W           = 32;
   localparam int POS_W            = 8;
   localparam int ACT_W            = 3;
   localparam int STAT_W           = 2;
   localparam int DEFAULT_CAPACITY = 64;
   localparam int GROUP_SIZE       = 8;
   localparam int REQ_TDATA_W      = 48;
   localparam int RSP_TDATA_W      = 48;

   typedef enum logic [ACT_W-1:0] {
      ACT_READ      = 3'd0,
      ACT_INS_FRONT = 3'd1,
      ACT_INS_BACK  = 3'd2,
      ACT_INS_POS   = 3'd3,
      ACT_DELETE    = 3'd4
   } action_type;

   typedef enum logic [STAT_W-1:0] {
      ST_DONE  = 2'd0,
      ST_RANGE = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   // Broadcast control seen by every cell of the chain.
   typedef struct packed {
      logic              ins_en;
      logic              del_en;
      logic [POS_W-1:0]  pos;
      logic [DATA_W-1:0] value;
   } cell_ctrl_type;

endpackage

[rtl/indexed_sequence_store_core.sv]
// After acceptance, a request passes the stage-one register, then the result word register.
// Throughput: one request word per cycle while the result side keeps taking words.
// Every accepted insert or delete shifts the cells from its position up in the accept
// cycle; a read goes through a registered two-level OR tree over the cell taps.
// Reset clears the stored count and the pipeline valids; cell contents are not cleared.
module indexed_sequence_store_core
   import isstore_pkg::*;
#(
   parameter int CAPACITY = DEFAULT_CAPACITY
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // action [2:0], position [10:3], value_in [42:11], zero fill above
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // read_value [31:0], status [33:32], length [41:34], zero fill above
   output logic [RSP_TDATA_W-1:0] rsp_tdata
);

   localparam int NGROUP = (CAPACITY + GROUP_SIZE - 1) / GROUP_SIZE;
   localparam logic [POS_W-1:0] CAP_COUNT = POS_W'(CAPACITY);

   // Request word fields.
   logic              req_fire;
   action_type        action;
   logic [POS_W-1:0]  position;
   logic [DATA_W-1:0] value_in;

   assign req_fire = req_tvalid & req_tready;
   assign action   = action_type'(req_tdata[2:0]);
   assign position = req_tdata[10:3];
   assign value_in = req_tdata[42:11];

   logic [POS_W-1:0] count_ff;
   logic [POS_W-1:0] count_in;

   logic             ins_ok;
   logic             del_ok;
   logic             read_ok;
   logic [POS_W-1:0] ins_at;
   status_type       status;

   // Decode the request against the current count.
   always_comb begin
      ins_ok   = 1'b0;
      del_ok   = 1'b0;
      read_ok  = 1'b0;
      ins_at   = '0;
      status   = ST_DONE;
      count_in = count_ff;
      unique case (action) inside
         ACT_READ: begin
            if (position < count_ff) begin
               read_ok = 1'b1;
            end else begin
               status = ST_RANGE;
            end
         end
         ACT_INS_FRONT, ACT_INS_BACK, ACT_INS_POS: begin
            if (action == ACT_INS_FRONT) begin
               ins_at = '0;
            end else if (action == ACT_INS_BACK) begin
               ins_at = count_ff;
            end else begin
               ins_at = position;
            end
            if (ins_at > count_ff) begin
               status = ST_RANGE;
            end else if (count_ff >= CAP_COUNT) begin
               status = ST_FULL;
            end else begin
               ins_ok   = 1'b1;
               count_in = count_ff + POS_W'(1);
            end
         end
         ACT_DELETE: begin
            if (position < count_ff) begin
               del_ok   = 1'b1;
               count_in = count_ff - POS_W'(1);
            end else begin
               status = ST_RANGE;
            end
         end
         default: begin
            status = ST_RANGE;
         end
      endcase
   end

   // Control broadcast to the cell chain.
   cell_ctrl_type ctrl;

   always_comb begin
      ctrl.ins_en = req_fire & ins_ok;
      ctrl.del_en = req_fire & del_ok;
      ctrl.pos    = ins_ok ? ins_at : position;
      ctrl.value  = value_in;
   end

   // The chain of cells, each wired to its two neighbors.
   logic [DATA_W-1:0] cell_value [CAPACITY];
   logic [DATA_W-1:0] cell_tap   [CAPACITY];

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [DATA_W-1:0] left_value;
      logic [DATA_W-1:0] right_value;

      if (i == 0) begin : g_first
         assign left_value = '0;
      end else begin : g_mid_left
         assign left_value = cell_value[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign right_value = '0;
      end else begin : g_mid_right
         assign right_value = cell_value[i+1];
      end

      isstore_cell #(
         .INDEX(i)
      ) u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .left_value (left_value),
         .right_value(right_value),
         .value      (cell_value[i]),
         .read_tap   (cell_tap[i])
      );
   end

   // First level of the read tree: OR the taps of each group of cells.
   logic [DATA_W-1:0] group_or [NGROUP];

   always_comb begin
      for (int g = 0; g < NGROUP; g++) begin
         group_or[g] = '0;
         for (int k = 0; k < GROUP_SIZE; k++) begin
            if (g * GROUP_SIZE + k < CAPACITY) begin
               group_or[g] = group_or[g] | cell_tap[g * GROUP_SIZE + k];
            end
         end
      end
   end

   // Pipeline stage one and the result word register.
   logic              s1_valid_ff;
   logic              s1_read_ok_ff;
   status_type        s1_status_ff;
   logic [POS_W-1:0]  s1_length_ff;
   logic [DATA_W-1:0] s1_group_ff [NGROUP];

   logic                   rsp_valid_ff;
   logic [RSP_TDATA_W-1:0] rsp_data_ff;

   logic s1_advance;
   assign s1_advance = s1_valid_ff & (~rsp_valid_ff | rsp_tready);
   assign req_tready = ~s1_valid_ff | s1_advance;

   // Second level of the read tree and the result word.
   logic [DATA_W-1:0]      read_or;
   logic [DATA_W-1:0]      read_value;
   logic [RSP_TDATA_W-1:0] rsp_data_in;

   always_comb begin
      read_or = '0;
      for (int g = 0; g < NGROUP; g++) begin
         read_or = read_or | s1_group_ff[g];
      end
      read_value  = s1_read_ok_ff ? read_or : '1;
      rsp_data_in = {6'b0, s1_length_ff, s1_status_ff, read_value};
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_fire) begin
            count_ff <= count_in;
         end
         if (req_fire) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_advance) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_read_ok_ff <= read_ok;
         s1_status_ff  <= status;
         s1_length_ff  <= count_in;
         for (int g = 0; g < NGROUP; g++) begin
            s1_group_ff[g] <= group_or[g];
         end
      end
      if (s1_advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

[rtl/isstore_cell.sv]
// One storage cell of the chain: holds a value and shifts with its neighbors.
module isstore_cell
   import isstore_pkg::*;
#(
   parameter int INDEX = 0
) (
   input  logic                clock,
   input  cell_ctrl_type       ctrl,
   input  logic [DATA_W-1:0]   left_value,
   input  logic [DATA_W-1:0]   right_value,
   output logic [DATA_W-1:0]   value,
   output logic [DATA_W-1:0]   read_tap
);

   localparam logic [POS_W-1:0] MY_INDEX = POS_W'(INDEX);

   logic [DATA_W-1:0] value_ff;
   logic [DATA_W-1:0] value_in;

   // Insert opens a gap at the position, delete closes the one there.
   always_comb begin
      value_in = value_ff;
      if (ctrl.ins_en) begin
         if (MY_INDEX > ctrl.pos) begin
            value_in = left_value;
         end else if (MY_INDEX == ctrl.pos) begin
            value_in = ctrl.value;
         end
      end else if (ctrl.del_en) begin
         if (MY_INDEX >= ctrl.pos) begin
            value_in = right_value;
         end
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   // The cell drives its value onto the read tree only when addressed.
   assign value    = value_ff;
   assign read_tap = (MY_INDEX == ctrl.pos) ? value_ff : '0;

endmodule

[verif/tb.sv]
// Self-checking testbench for the indexed sequence store core.
module tb
   import isstore_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int STORE_DEPTH    = DEFAULT_CAPACITY;
   localparam int RANDOM_WORDS   = 200;
   localparam int QUIET_WORDS    = 60;
   localparam int HOLD_WORDS     = 40;
   localparam int LONG_HOLD      = 200;
   localparam int WATCHDOG_LIMIT = 3000;

   localparam logic [DATA_W-1:0] NEG_ONE = '1;
   localparam logic [DATA_W-1:0] MAX_POS = 32'h7FFF_FFFF;
   localparam logic [DATA_W-1:0] MIN_NEG = 32'h8000_0000;

   // Action codes the package leaves undefined; the block must refuse them.
   localparam logic [ACT_W-1:0] ACT_SPARE_A = 3'd5;
   localparam logic [ACT_W-1:0] ACT_SPARE_B = 3'd6;
   localparam logic [ACT_W-1:0] ACT_SPARE_C = 3'd7;

   typedef struct packed {
      logic [DATA_W-1:0] read_value;
      logic [STAT_W-1:0] status;
      logic [POS_W-1:0]  length;
   } rsp_fields_type;

   typedef struct packed {
      logic [ACT_W-1:0]  act;
      logic [POS_W-1:0]  pos;
      logic [DATA_W-1:0] val;
      logic              typed;
      rsp_fields_type    want;
   } step_row_type;

   typedef enum logic [1:0] {MODE_GROW, MODE_SHRINK} fill_mode_type;

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;

   // Shadow copy of the stored sequence, advanced once per accepted word.
   logic [DATA_W-1:0] seq_cells [STORE_DEPTH];
   int                seq_len;
   rsp_fields_type    pending_rsp [$];

   fill_mode_type  fill_mode;
   rsp_fields_type got_rsp;
   rsp_fields_type want_rsp;
   rsp_fields_type no_rsp;
   bit          quiet_run;
   bit          hold_request;
   int          hold_cycles;
   int          stall_cycles;
   int          mismatch_count;
   int          issued_words;
   int          checked_words;
   int          useful_words;
   int          full_refusals;
   int          range_refusals;
   int          peak_length;

   // Directed opening: empty-list refusals, extremes, append at the count.
   step_row_type directed_steps [24] = '{
      '{ACT_READ,      8'd0,   32'd0,   1'b1, '{NEG_ONE, ST_RANGE, 8'd0}},
      '{ACT_DELETE,    8'd0,   32'd0,   1'b1, '{NEG_ONE, ST_RANGE, 8'd0}},
      '{ACT_INS_POS,   8'd1,   32'd5,   1'b1, '{NEG_ONE, ST_RANGE, 8'd0}},
      '{ACT_INS_POS,   8'd255, 32'd9,   1'b1, '{NEG_ONE, ST_RANGE, 8'd0}},
      '{ACT_SPARE_A,   8'd0,   32'd1,   1'b1, '{NEG_ONE, ST_RANGE, 8'd0}},
      '{ACT_SPARE_B,   8'd170, NEG_ONE, 1'b1, '{NEG_ONE, ST_RANGE, 8'd0}},
      '{ACT_SPARE_C,   8'd85,  MIN_NEG, 1'b1, '{NEG_ONE, ST_RANGE, 8'd0}},
      '{ACT_INS_FRONT, 8'd0,   MAX_POS, 1'b1, '{NEG_ONE, ST_DONE,  8'd1}},
      '{ACT_INS_BACK,  8'd255, MIN_NEG, 1'b1, '{NEG_ONE, ST_DONE,  8'd2}},
      '{ACT_INS_POS,   8'd1,   32'd0,   1'b1, '{NEG_ONE, ST_DONE,  8'd3}},
      '{ACT_INS_POS,   8'd3,   NEG_ONE, 1'b1, '{NEG_ONE, ST_DONE,  8'd4}},
      '{ACT_READ,      8'd0,   32'd0,   1'b1, '{MAX_POS, ST_DONE,  8'd4}},
      '{ACT_READ,      8'd3,   32'd0,   1'b1, '{NEG_ONE, ST_DONE,  8'd4}},
      '{ACT_READ,      8'd2,   32'd0,   1'b1, '{MIN_NEG, ST_DONE,  8'd4}},
      '{ACT_READ,      8'd4,   32'd0,   1'b1, '{NEG_ONE, ST_RANGE, 8'd4}},
      '{ACT_READ,      8'd255, 32'd0,   1'b1, '{NEG_ONE, ST_RANGE, 8'd4}},
      '{ACT_DELETE,    8'd4,   32'd0,   1'b1, '{NEG_ONE, ST_RANGE, 8'd4}},
      '{ACT_DELETE,    8'd255, 32'd0,   1'b1, '{NEG_ONE, ST_RANGE, 8'd4}},
      '{ACT_DELETE,    8'd0,   32'd0,   1'b1, '{NEG_ONE, ST_DONE,  8'd3}},
      '{ACT_READ,      8'd0,   32'd0,   1'b1, '{32'd0,   ST_DONE,  8'd3}},
      '{ACT_INS_FRONT, 8'd0,   32'h1234_5678, 1'b0, '0},
      '{ACT_INS_POS,   8'd2,   32'hA5A5_A5A5, 1'b0, '0},
      '{ACT_DELETE,    8'd4,   32'd0,   1'b0, '0},
      '{ACT_READ,      8'd1,   32'd0,   1'b0, '0}
   };

   indexed_sequence_store_core #(
      .CAPACITY(STORE_DEPTH)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata)
   );

   initial clock = 1'b0;
   always #2 clock = ~clock;

   // Insert into the shadow sequence, refusing past-the-end before full.
   function automatic logic [STAT_W-1:0] place_value(int at, logic [DATA_W-1:0] val);
      int slot;
      if (at > seq_len) return ST_RANGE;
      if (seq_len >= STORE_DEPTH) return ST_FULL;
      for (slot = seq_len; slot > at; slot--) seq_cells[slot] = seq_cells[slot-1];
      seq_cells[at] = val;
      seq_len++;
      return ST_DONE;
   endfunction

   // Apply one request to the shadow sequence and return the result it gives.
   function automatic rsp_fields_type predict_response(logic [ACT_W-1:0] act,
                                                       logic [POS_W-1:0] pos,
                                                       logic [DATA_W-1:0] val);
      rsp_fields_type r;
      int slot;
      r.read_value = NEG_ONE;
      r.status     = ST_DONE;
      case (act)
         ACT_READ: begin
            if (int'(pos) < seq_len) r.read_value = seq_cells[pos];
            else r.status = ST_RANGE;
         end
         ACT_INS_FRONT: r.status = place_value(0, val);
         ACT_INS_BACK:  r.status = place_value(seq_len, val);
         ACT_INS_POS:   r.status = place_value(int'(pos), val);
         ACT_DELETE: begin
            if (int'(pos) < seq_len) begin
               for (slot = pos; slot + 1 < seq_len; slot++) seq_cells[slot] = seq_cells[slot+1];
               seq_len--;
            end else begin
               r.status = ST_RANGE;
            end
         end
         default: r.status = ST_RANGE;
      endcase
      r.length = seq_len[POS_W-1:0];
      return r;
   endfunction

   // Mostly random values, with the signed extremes mixed in.
   function automatic logic [DATA_W-1:0] pick_value();
      case ($urandom_range(0, 15))
         0:       return MAX_POS;
         1:       return MIN_NEG;
         2:       return NEG_ONE;
         3:       return '0;
         default: return $urandom;
      endcase
   endfunction

   task automatic flag_mismatch(string what, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
      $display("MISMATCH at %0t: %s expected 0x%08h got 0x%08h", $realtime, what, want, got);
      mismatch_count++;
   endtask

   // Offer one request word, wait for its acceptance, then log what must come back.
   task automatic issue_request(logic [ACT_W-1:0] act, logic [POS_W-1:0] pos,
                                logic [DATA_W-1:0] val, logic typed,
                                rsp_fields_type typed_rsp);
      int gap;
      rsp_fields_type predicted;
      gap = (!quiet_run && $urandom_range(0, 9) == 0) ? $urandom_range(1, 16) : 0;
      if (gap != 0) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= {{(REQ_TDATA_W-ACT_W-POS_W-DATA_W){1'b0}}, val, pos, act};
      do @(posedge clock); while (!req_tready);
      predicted = predict_response(act, pos, val);
      pending_rsp.push_back(typed ? typed_rsp : predicted);
      issued_words++;
      if (predicted.status == ST_DONE) useful_words++;
      if (predicted.status == ST_FULL) full_refusals++;
      if (predicted.status == ST_RANGE) range_refusals++;
      if (seq_len > peak_length) peak_length = seq_len;
   endtask

   // Well-formed requests follow the fill mode; about one in ten is noise.
   task automatic issue_random();
      logic [ACT_W-1:0] act;
      logic [POS_W-1:0] pos;
      int roll;
      roll = $urandom_range(0, 99);
      if (seq_len == STORE_DEPTH) fill_mode = MODE_SHRINK;
      else if (seq_len == 0) fill_mode = MODE_GROW;
      else if ($urandom_range(0, 49) == 0) fill_mode = fill_mode_type'(!fill_mode);
      if (roll < 10) begin
         act = ACT_W'($urandom_range(0, 7));
         pos = POS_W'($urandom_range(0, 255));
      end else begin
         if (fill_mode == MODE_GROW) begin
            if (roll < 65) act = ACT_W'($urandom_range(ACT_INS_FRONT, ACT_INS_POS));
            else if (roll < 88) act = ACT_READ;
            else act = ACT_DELETE;
         end else begin
            if (roll < 60) act = ACT_DELETE;
            else if (roll < 85) act = ACT_READ;
            else act = ACT_W'($urandom_range(ACT_INS_FRONT, ACT_INS_POS));
         end
         if (act == ACT_INS_POS) pos = POS_W'($urandom_range(0, seq_len));
         else pos = (seq_len == 0) ? 8'd0 : 8'($urandom_range(0, seq_len - 1));
      end
      issue_request(act, pos, pick_value(), 1'b0, no_rsp);
   endtask

   task automatic wait_for_drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
   endtask

   // Result side: random back-pressure bursts, plus one long hold on request.
   initial begin
      rsp_tready = 1'b0;
      wait (!reset);
      forever begin
         @(negedge clock);
         if (hold_request) begin
            rsp_tready <= 1'b0;
            hold_cycles = 0;
            while (hold_cycles < LONG_HOLD) begin
               @(negedge clock);
               hold_cycles++;
            end
            hold_request = 1'b0;
            rsp_tready <= 1'b1;
         end else if (!quiet_run && $urandom_range(0, 7) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge clock);
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Compare every result word with the oldest outstanding expectation.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         got_rsp.read_value = rsp_tdata[31:0];
         got_rsp.status     = rsp_tdata[33:32];
         got_rsp.length     = rsp_tdata[41:34];
         if (pending_rsp.size() == 0) begin
            flag_mismatch("unexpected result word, read_value", '0, got_rsp.read_value);
         end else begin
            want_rsp = pending_rsp.pop_front();
            checked_words++;
            if (got_rsp.read_value !== want_rsp.read_value)
               flag_mismatch("read_value", want_rsp.read_value, got_rsp.read_value);
            if (got_rsp.status !== want_rsp.status)
               flag_mismatch("status", 32'(want_rsp.status), 32'(got_rsp.status));
            if (got_rsp.length !== want_rsp.length)
               flag_mismatch("length", 32'(want_rsp.length), 32'(got_rsp.length));
         end
      end
   end

   // Watchdog: too long without any word moving on either side ends the run.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog expired with %0d result words outstanding.", pending_rsp.size());
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   // Main sequence.
   initial begin
      reset          = 1'b1;
      req_tvalid     = 1'b0;
      req_tdata      = '0;
      no_rsp         = '0;
      seq_len        = 0;
      quiet_run      = 1'b0;
      hold_request   = 1'b0;
      mismatch_count = 0;
      issued_words   = 0;
      checked_words  = 0;
      useful_words   = 0;
      full_refusals  = 0;
      range_refusals = 0;
      peak_length    = 0;
      fill_mode      = MODE_GROW;
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      // Directed rows; typed rows carry their own expected word.
      foreach (directed_steps[i])
         issue_request(directed_steps[i].act, directed_steps[i].pos, directed_steps[i].val,
                       directed_steps[i].typed, directed_steps[i].want);

      // Fill to capacity, then probe every insert kind and the edges of a full list.
      while (seq_len < STORE_DEPTH)
         issue_request(ACT_W'($urandom_range(ACT_INS_FRONT, ACT_INS_POS)),
                       POS_W'($urandom_range(0, seq_len)), pick_value(), 1'b0, no_rsp);
      issue_request(ACT_INS_FRONT, 8'd0, pick_value(), 1'b0, no_rsp);
      issue_request(ACT_INS_BACK, 8'd0, pick_value(), 1'b0, no_rsp);
      issue_request(ACT_INS_POS, 8'd10, pick_value(), 1'b0, no_rsp);
      issue_request(ACT_INS_POS, 8'(STORE_DEPTH), pick_value(), 1'b0, no_rsp);
      issue_request(ACT_INS_POS, 8'd200, pick_value(), 1'b0, no_rsp);
      issue_request(ACT_READ, 8'(STORE_DEPTH - 1), '0, 1'b0, no_rsp);
      issue_request(ACT_READ, 8'(STORE_DEPTH), '0, 1'b0, no_rsp);
      issue_request(ACT_DELETE, 8'(STORE_DEPTH), '0, 1'b0, no_rsp);
      issue_request(ACT_DELETE, 8'(STORE_DEPTH - 1), '0, 1'b0, no_rsp);

      // Long result-side hold while requests keep coming, so the input stalls.
      hold_request = 1'b1;
      repeat (HOLD_WORDS) issue_random();

      // Sender pause until every outstanding result is back.
      wait_for_drain();

      repeat (RANDOM_WORDS) issue_random();

      // Closing stretch at full rate on both sides.
      quiet_run = 1'b1;
      repeat (QUIET_WORDS) issue_random();

      wait_for_drain();
      repeat (8) @(posedge clock);

      $display("Covered %0d request words (%0d applied) and checked %0d result words; peak length %0d.",
               issued_words, useful_words, checked_words, peak_length);
      $display("Refusals seen: %0d list full, %0d out of range or undefined action.",
               full_refusals, range_refusals);
      if (mismatch_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

[sim.f]
rtl/isstore_pkg.sv
rtl/isstore_cell.sv
rtl/indexed_sequence_store_core.sv
verif/tb.sv
